>>> hdl/occupancy_detector_hysteresis_unit_defines.svh
// Assertion macros shared by the occupancy detector RTL.
// Simulation builds get real checks; synthesis builds get empty bodies.
`ifndef OCCUPANCY_DETECTOR_HYSTERESIS_UNIT_DEFINES_SVH
`define OCCUPANCY_DETECTOR_HYSTERESIS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is asserted (active low)
`define ODH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("odh assertion failed");

// Checked property that also holds during reset
`define ODH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("odh assertion failed");

`else

`define ODH_ASSERT(lbl, clk, rst_n, prop)
`define ODH_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/odh_pkg.sv
// Package for the occupancy detector: widths, mode codes, register indexes,
// reset values and the state/config structs. No dependencies.
package odh_pkg;

    localparam int DIST_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 8;
    localparam int MODE_W  = 2;

    // Occupancy mode codes
    localparam logic [MODE_W-1:0] MODE_FREE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OCCUPIED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_OCC_THRESHOLD = 8'd0;
    localparam logic [IDX_W-1:0] REG_HYST_WIDTH    = 8'd1;
    localparam logic [IDX_W-1:0] REG_ENTRY_DELAY   = 8'd2;
    localparam logic [IDX_W-1:0] REG_EXIT_DELAY    = 8'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_OCC_THRESHOLD = 16'd1000;
    localparam logic [CFG_W-1:0] RST_HYST_WIDTH    = 16'd200;
    localparam logic [CFG_W-1:0] RST_ENTRY_DELAY   = 16'd2000;
    localparam logic [CFG_W-1:0] RST_EXIT_DELAY    = 16'd2000;

    // Invalid run length before the error mode is forced
    localparam logic [TIME_W-1:0] FAULT_HOLD_MS = 32'd500;

    typedef struct packed {
        logic [CFG_W-1:0] occ_threshold;
        logic [CFG_W-1:0] hyst_width;
        logic [CFG_W-1:0] entry_delay;
        logic [CFG_W-1:0] exit_delay;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pending_on;
        logic [TIME_W-1:0] pending_start;
        logic              fault_on;
        logic [TIME_W-1:0] fault_start;
    } t_state;

endpackage

>>> hdl/occupancy_detector_hysteresis_unit.sv
// Top level of the occupancy detector with hysteresis and debounce timers.
// Depends on odh_pkg, odh_step and occupancy_detector_hysteresis_unit_defines.svh.
//
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+----------------------------------
// in      | input     | i_in_valid / o_in_ready   | i_distance, i_reading_ok, i_time_ms
// out     | output    | o_out_valid / i_out_ready | o_occupancy
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled: a word is held in the
// input register, then the mode update runs combinationally into the output
// register. Throughput is one word per cycle unless the output stalls.
// A stalled output holds both registers; the input side keeps taking a word
// while the input register is empty. Synchronous active-low reset; no
// clearing pass. Config writes are always accepted.
module occupancy_detector_hysteresis_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [odh_pkg::DIST_W-1:0]    i_distance,
    input  logic                          i_reading_ok,
    input  logic [odh_pkg::TIME_W-1:0]    i_time_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [odh_pkg::MODE_W-1:0]    o_occupancy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [odh_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [odh_pkg::CFG_W-1:0]     i_cfg_data
);
    import odh_pkg::*;
    `include "occupancy_detector_hysteresis_unit_defines.svh"

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    logic              r_in_valid;
    logic [DIST_W-1:0] r_in_distance;
    logic              r_in_ok;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    logic [MODE_W-1:0] r_out_occupancy;
    logic              step;

    // Stage 2 fires when the output register is free or being drained
    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_occupancy = r_out_occupancy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.occ_threshold <= RST_OCC_THRESHOLD;
            r_cfg.hyst_width    <= RST_HYST_WIDTH;
            r_cfg.entry_delay   <= RST_ENTRY_DELAY;
            r_cfg.exit_delay    <= RST_EXIT_DELAY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OCC_THRESHOLD: r_cfg.occ_threshold <= i_cfg_data;
                REG_HYST_WIDTH:    r_cfg.hyst_width    <= i_cfg_data;
                REG_ENTRY_DELAY:   r_cfg.entry_delay   <= i_cfg_data;
                REG_EXIT_DELAY:    r_cfg.exit_delay    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_distance <= i_distance;
            r_in_ok       <= i_reading_ok;
            r_in_time     <= i_time_ms;
        end
    end

    // Mode update logic
    odh_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_distance   (r_in_distance),
        .i_reading_ok (r_in_ok),
        .i_time_ms    (r_in_time),
        .o_state      (n_state)
    );

    // Detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= MODE_ERROR;
            r_state.pending_on    <= 1'b0;
            r_state.pending_start <= '0;
            r_state.fault_on      <= 1'b0;
            r_state.fault_start   <= '0;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_occupancy <= n_state.mode;
        end
    end

    // Checks
    `ODH_ASSERT(a_mode_legal, i_clk, i_rst_n, r_state.mode == MODE_FREE || r_state.mode == MODE_OCCUPIED || r_state.mode == MODE_ERROR)
    `ODH_ASSERT(a_no_pending_in_error, i_clk, i_rst_n, r_state.pending_on |-> r_state.mode != MODE_ERROR)
    `ODH_ASSERT(a_bad_reading_cancels, i_clk, i_rst_n, (step && !r_in_ok) |=> !r_state.pending_on)
    `ODH_ASSERT(a_error_exit, i_clk, i_rst_n, (step && r_in_ok && r_state.mode == MODE_ERROR) |=> r_state.mode != MODE_ERROR)

endmodule

>>> hdl/odh_step.sv
// Next-state logic of the occupancy detector for one reading.
// Purely combinational; uses odh_pkg types and constants.
module odh_step (
    input  odh_pkg::t_cfg                 i_cfg,
    input  odh_pkg::t_state               i_state,
    input  logic [odh_pkg::DIST_W-1:0]    i_distance,
    input  logic                          i_reading_ok,
    input  logic [odh_pkg::TIME_W-1:0]    i_time_ms,
    output odh_pkg::t_state               o_state
);
    import odh_pkg::*;

    logic [DIST_W:0]   free_thr;
    logic              occ_cond;
    logic              free_cond;
    logic [TIME_W-1:0] fault_base;
    logic [TIME_W-1:0] fault_elapsed;
    logic [TIME_W-1:0] pend_base;
    logic [TIME_W-1:0] pend_elapsed;

    // Thresholds, 17-bit free threshold never wraps
    assign free_thr  = {1'b0, i_cfg.occ_threshold} + {1'b0, i_cfg.hyst_width};
    assign occ_cond  = i_distance <= i_cfg.occ_threshold;
    assign free_cond = {1'b0, i_distance} > free_thr;

    // Timer origins: a timer that is not running starts now
    assign fault_base    = i_state.fault_on ? i_state.fault_start : i_time_ms;
    assign fault_elapsed = i_time_ms - fault_base;
    assign pend_base     = i_state.pending_on ? i_state.pending_start : i_time_ms;
    assign pend_elapsed  = i_time_ms - pend_base;

    // Mode update
    always_comb begin
        o_state = i_state;
        if (!i_reading_ok) begin
            o_state.pending_on  = 1'b0;
            o_state.fault_on    = 1'b1;
            o_state.fault_start = fault_base;
            if (fault_elapsed >= FAULT_HOLD_MS) begin
                o_state.mode = MODE_ERROR;
            end
        end else begin
            o_state.fault_on = 1'b0;
            case (i_state.mode)
                MODE_ERROR: begin
                    o_state.mode       = occ_cond ? MODE_OCCUPIED : MODE_FREE;
                    o_state.pending_on = 1'b0;
                end
                MODE_FREE: begin
                    if (occ_cond) begin
                        o_state.pending_start = pend_base;
                        o_state.pending_on    = 1'b1;
                        if (pend_elapsed >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.entry_delay}) begin
                            o_state.mode       = MODE_OCCUPIED;
                            o_state.pending_on = 1'b0;
                        end
                    end else begin
                        o_state.pending_on = 1'b0;
                    end
                end
                MODE_OCCUPIED: begin
                    if (free_cond) begin
                        o_state.pending_start = pend_base;
                        o_state.pending_on    = 1'b1;
                        if (pend_elapsed >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.exit_delay}) begin
                            o_state.mode       = MODE_FREE;
                            o_state.pending_on = 1'b0;
                        end
                    end else begin
                        o_state.pending_on = 1'b0;
                    end
                end
                default: begin
                    // unused code: mode held, only the fault run ends
                end
            endcase
        end
    end

endmodule

>>> sim/tb_occupancy_detector_hysteresis_unit.sv
// Self-checking testbench for occupancy_detector_hysteresis_unit: directed timing,
// fault and wrap cases, then random reading streams under several register settings.
// Depends on odh_pkg and the RTL of the block; the expected mode is computed in place.
module tb_occupancy_detector_hysteresis_unit;

    import odh_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int GAP_PCT = 22;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic [DIST_W-1:0]   in_distance = '0;
    logic                in_reading_ok = 1'b0;
    logic [TIME_W-1:0]   in_time_ms = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                no_gaps = 1'b0;
    wire                 o_in_ready;
    wire                 o_out_valid;
    wire  [MODE_W-1:0]   o_occupancy;
    wire                 o_cfg_ready;

    // Shadow registers and detector state for the expected mode
    t_cfg                cfg_shadow;
    t_state              det_state;
    logic [MODE_W-1:0]   occupancy_due[$];
    int                  mismatch_count = 0;
    int                  results_seen = 0;
    int                  idle_cycles = 0;

    occupancy_detector_hysteresis_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_distance   (in_distance),
        .i_reading_ok (in_reading_ok),
        .i_time_ms    (in_time_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_occupancy  (o_occupancy),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH: %s", what);
        mismatch_count++;
    endtask

    // Debounce timer: arm on first qualifying reading, report when delay has run out
    function automatic logic timer_expired(input logic [TIME_W-1:0] now,
                                           input logic [CFG_W-1:0] delay);
        logic [TIME_W-1:0] elapsed;
        if (!det_state.pending_on) begin
            det_state.pending_start = now;
            det_state.pending_on = 1'b1;
        end
        elapsed = now - det_state.pending_start;
        return elapsed >= {16'd0, delay};
    endfunction

    // Mode after one reading; updates the shadow detector state
    function automatic logic [MODE_W-1:0] next_occupancy(input logic [DIST_W-1:0] dist_mm,
                                                         input logic ok,
                                                         input logic [TIME_W-1:0] now);
        logic [16:0]       release_thr;
        logic [TIME_W-1:0] fault_age;
        release_thr = {1'b0, cfg_shadow.occ_threshold} + {1'b0, cfg_shadow.hyst_width};
        if (!ok) begin
            det_state.pending_on = 1'b0;
            if (!det_state.fault_on) begin
                det_state.fault_start = now;
                det_state.fault_on = 1'b1;
            end
            fault_age = now - det_state.fault_start;
            if (fault_age >= FAULT_HOLD_MS)
                det_state.mode = MODE_ERROR;
        end else begin
            det_state.fault_on = 1'b0;
            case (det_state.mode)
                MODE_ERROR: begin
                    det_state.mode = (dist_mm <= cfg_shadow.occ_threshold) ? MODE_OCCUPIED
                                                                            : MODE_FREE;
                    det_state.pending_on = 1'b0;
                end
                MODE_FREE: begin
                    if (dist_mm <= cfg_shadow.occ_threshold) begin
                        if (timer_expired(now, cfg_shadow.entry_delay)) begin
                            det_state.mode = MODE_OCCUPIED;
                            det_state.pending_on = 1'b0;
                        end
                    end else begin
                        det_state.pending_on = 1'b0;
                    end
                end
                MODE_OCCUPIED: begin
                    if ({1'b0, dist_mm} > release_thr) begin
                        if (timer_expired(now, cfg_shadow.exit_delay)) begin
                            det_state.mode = MODE_FREE;
                            det_state.pending_on = 1'b0;
                        end
                    end else begin
                        det_state.pending_on = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        return det_state.mode;
    endfunction

    // Send one reading word, with random idle cycles ahead of it
    task automatic send_reading(input logic [DIST_W-1:0] dist_mm, input logic ok,
                                input logic [TIME_W-1:0] stamp);
        while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        in_distance   <= dist_mm;
        in_reading_ok <= ok;
        in_time_ms    <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        occupancy_due.push_back(next_occupancy(dist_mm, ok, stamp));
    endtask

    // Drop the input valid and wait until every expected mode has come out
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (occupancy_due.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_OCC_THRESHOLD: cfg_shadow.occ_threshold = data;
            REG_HYST_WIDTH:    cfg_shadow.hyst_width = data;
            REG_ENTRY_DELAY:   cfg_shadow.entry_delay = data;
            REG_EXIT_DELAY:    cfg_shadow.exit_delay = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] hyst,
                              input logic [CFG_W-1:0] entry, input logic [CFG_W-1:0] leave);
        wait_for_idle();
        write_reg(REG_OCC_THRESHOLD, thr);
        write_reg(REG_HYST_WIDTH, hyst);
        write_reg(REG_ENTRY_DELAY, entry);
        write_reg(REG_EXIT_DELAY, leave);
        cfg_valid <= 1'b0;
    endtask

    // Reset config: error mode resolves at once, band edges at 1000 and 1200
    task automatic test_power_up_defaults();
        send_reading(16'd1000, 1'b1, 32'd0);
        send_reading(16'd1200, 1'b1, 32'd10);
        send_reading(16'd1201, 1'b1, 32'd20);
    endtask

    // Exit then entry delay, one ms short and exactly on time
    task automatic test_exit_and_entry_timing();
        send_reading(16'hFFFF, 1'b1, 32'd2019);
        send_reading(16'hFFFF, 1'b1, 32'd2020);
        send_reading(16'd0, 1'b1, 32'd2100);
        send_reading(16'd1000, 1'b1, 32'd4099);
        send_reading(16'd1000, 1'b1, 32'd4100);
    endtask

    // Invalid runs: short one keeps the mode, 500 ms forces error
    task automatic test_fault_hold();
        send_reading(16'd0, 1'b0, 32'd5000);
        send_reading(16'd0, 1'b0, 32'd5499);
        send_reading(16'd0, 1'b1, 32'd5500);
        send_reading(16'd0, 1'b0, 32'd6000);
        send_reading(16'hFFFF, 1'b0, 32'd6500);
        send_reading(16'hFFFF, 1'b1, 32'd6501);
    endtask

    // Elapsed time across the 2^32 wrap, and a timestamp going backwards
    task automatic test_timestamp_wrap();
        send_reading(16'd5, 1'b1, 32'hFFFF_FFF0);
        send_reading(16'd5, 1'b1, 32'h0000_07BF);
        send_reading(16'd5, 1'b1, 32'h0000_07C0);
        send_reading(16'd2000, 1'b1, 32'h0000_0100);
        send_reading(16'd2000, 1'b1, 32'h0000_00FF);
    endtask

    task automatic test_zero_delay();
        set_config(RST_OCC_THRESHOLD, RST_HYST_WIDTH, 16'd0, 16'd0);
        send_reading(16'd1000, 1'b1, 32'd100);
        send_reading(16'd1201, 1'b1, 32'd100);
    endtask

    // Release threshold beyond 16 bits, then both thresholds at zero
    task automatic test_threshold_extremes();
        set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_reading(16'hFFFF, 1'b1, 32'd200);
        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        send_reading(16'd0, 1'b1, 32'd300);
    endtask

    // Writes past the last register must leave the config alone
    task automatic test_ignored_register_index();
        wait_for_idle();
        write_reg(REG_EXIT_DELAY + 8'd1, 16'hFFFF);
        write_reg(8'hFF, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_reading(16'd1, 1'b1, 32'd400);
    endtask

    // Random reading stream: mostly steady distances with debounce-scale steps
    task automatic run_random_phase(input int count, input logic [TIME_W-1:0] start_ms,
                                    input int step_max);
        logic [TIME_W-1:0] now;
        int                bad_left;
        int                side;
        int                thr;
        int                rel;
        int                d;
        now = start_ms;
        bad_left = 0;
        side = 0;
        thr = cfg_shadow.occ_threshold;
        rel = thr + cfg_shadow.hyst_width;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 4) begin
                // noise word: anything at all, timestamp included
                send_reading(16'($urandom), 1'($urandom_range(1)), $urandom);
            end else begin
                now = now + $urandom_range(step_max);
                if (bad_left == 0 && $urandom_range(99) < 6)
                    bad_left = $urandom_range(25, 1);
                if ($urandom_range(99) < 12)
                    side = $urandom_range(3);
                case (side)
                    0: d = thr - $urandom_range(30);
                    1: d = rel + 1 + $urandom_range(30);
                    2: d = thr + $urandom_range(cfg_shadow.hyst_width);
                    default: d = $urandom_range(65535);
                endcase
                if (d < 0)
                    d = 0;
                if (d > 65535)
                    d = 65535;
                send_reading(d[DIST_W-1:0], bad_left == 0, now);
                if (bad_left > 0)
                    bad_left--;
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0] start_ms;
        int                step_max;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    set_config(RST_OCC_THRESHOLD, RST_HYST_WIDTH, RST_ENTRY_DELAY,
                               RST_EXIT_DELAY);
                    start_ms = 32'd0;
                    step_max = 400;
                end
                1: begin
                    set_config(16'($urandom), 16'($urandom_range(2000)),
                               16'($urandom_range(300)), 16'($urandom_range(300)));
                    start_ms = 32'hFFFF_F000;
                    step_max = 60;
                end
                2: begin
                    set_config(16'd0, 16'd0, 16'd0, 16'd0);
                    start_ms = $urandom;
                    step_max = 40;
                end
                3: begin
                    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    start_ms = $urandom;
                    step_max = 9000;
                end
                4: begin
                    set_config(16'($urandom_range(65535, 64000)), 16'($urandom),
                               16'($urandom_range(500)), 16'($urandom_range(500)));
                    start_ms = $urandom;
                    step_max = 80;
                end
                default: begin
                    set_config(16'($urandom), 16'($urandom_range(4000)),
                               16'($urandom_range(1000)), 16'($urandom_range(1000)));
                    start_ms = $urandom;
                    step_max = $urandom_range(200, 20);
                end
            endcase
            // one phase runs back to back on both sides
            no_gaps <= (p == 1);
            run_random_phase(190, start_ms, step_max);
        end
    endtask

    // Output side: random stalls, compare each word with the oldest expectation
    always @(posedge i_clk) begin
        logic [MODE_W-1:0] want;
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (occupancy_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d: occupancy %0d with nothing expected",
                                        results_seen, o_occupancy));
            end else begin
                want = occupancy_due.pop_front();
                if (o_occupancy !== want)
                    flag_mismatch($sformatf("result %0d: occupancy %0d, expected %0d",
                                            results_seen, o_occupancy, want));
            end
        end
        out_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end

    // Watchdog: too many cycles without any handshake ends the run
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        cfg_shadow.occ_threshold = RST_OCC_THRESHOLD;
        cfg_shadow.hyst_width    = RST_HYST_WIDTH;
        cfg_shadow.entry_delay   = RST_ENTRY_DELAY;
        cfg_shadow.exit_delay    = RST_EXIT_DELAY;
        det_state.mode           = MODE_ERROR;
        det_state.pending_on     = 1'b0;
        det_state.pending_start  = '0;
        det_state.fault_on       = 1'b0;
        det_state.fault_start    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up_defaults();
        test_exit_and_entry_timing();
        test_fault_hold();
        test_timestamp_wrap();
        test_zero_delay();
        test_threshold_extremes();
        test_ignored_register_index();
        test_random_traffic();

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (occupancy_due.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    occupancy_due.size()));
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
